// File: hdl/smlse_pkg.sv
// ----------------------------------------------------------------------------
// smlse_pkg
// Shared types and constants of the soft-minimum block.
// ----------------------------------------------------------------------------
package smlse_pkg;

   typedef struct packed {
      logic signed [31:0] height;
      logic               set_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] soft_min;
      logic [16:0]        weight;
      logic [3:0]         height_index;
      logic               run_end;
      logic               overflow;
   } rsp_type;

   // head of the input queue as seen by the back end
   typedef struct packed {
      logic    valid;
      req_type item;
   } fq_type;

   // command to the shared multiply / divide unit
   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [63:0] a;
      logic [63:0] b;
   } alu_cmd_type;

   // status of the unit: product {hi, lo}, quotient in lo
   typedef struct packed {
      logic        done;
      logic [63:0] hi;
      logic [63:0] lo;
   } alu_rsp_type;

   localparam logic [63:0]        Q32_ONE      = 64'h0000_0001_0000_0000;
   localparam logic [63:0]        EXP_NEG_ONE  = 64'd1580030169;
   localparam logic [39:0]        LN_TWO       = 40'd2977044472;
   localparam logic [63:0]        EXP_CUTOFF   = 64'd786432;
   localparam logic [3:0]         TAYLOR_LAST  = 4'd13;
   localparam logic [2:0]         LOG_LAST     = 3'd7;
   localparam logic signed [31:0] MIN_RESET    = 32'sh7FFF_FFFF;
   localparam logic [30:0]        SMOOTH_RESET = 31'd655;
   localparam logic [5:0]         ALU_STEPS    = 6'd63;

endpackage

// File: hdl/smlse_front.sv
// ----------------------------------------------------------------------------
// smlse_front
// Input side: takes height words and queues them for the back end.
// ----------------------------------------------------------------------------
module smlse_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  smlse_pkg::req_type req_data,
   output smlse_pkg::fq_type  fq,
   input  logic               pop
);
   import smlse_pkg::*;

   req_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       take;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign take      = pop && (cnt_ff != 2'd0);
   assign fq.valid  = (cnt_ff != 2'd0);
   assign fq.item   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = take ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hdl/smlse_alu.sv
// ----------------------------------------------------------------------------
// smlse_alu
// Shared 64-bit multiplier and divider, one bit per cycle.
// ----------------------------------------------------------------------------
module smlse_alu (
   input  logic                   clock,
   input  logic                   reset,
   input  smlse_pkg::alu_cmd_type cmd,
   output smlse_pkg::alu_rsp_type rsp
);
   import smlse_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] a_ff;
   logic [64:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;
   logic [64:0] add_sum;
   logic [64:0] trial;
   logic        fits;

   assign rsp.done = done_ff;
   assign rsp.hi   = hi_ff[63:0];
   assign rsp.lo   = lo_ff;

   always_comb begin
      add_sum = hi_ff + (lo_ff[0] ? {1'b0, a_ff} : 65'd0);
      trial   = {hi_ff[63:0], lo_ff[63]};
      fits    = (trial >= {1'b0, a_ff});
      if (div_ff) begin
         hi_in = fits ? (trial - {1'b0, a_ff}) : trial;
         lo_in = {lo_ff[62:0], fits};
      end else begin
         hi_in = {1'b0, add_sum[64:1]};
         lo_in = {add_sum[0], lo_ff[63:1]};
      end
      busy_in = busy_ff && (cnt_ff != ALU_STEPS);
      done_in = busy_ff && (cnt_ff == ALU_STEPS);
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         // divide keeps the divisor in a_ff and shifts the dividend in lo
         div_ff <= cmd.is_div;
         a_ff   <= cmd.is_div ? cmd.b : cmd.a;
         lo_ff  <= cmd.is_div ? cmd.a : cmd.b;
         hi_ff  <= 65'd0;
         cnt_ff <= 6'd0;
      end else if (busy_ff) begin
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= cmd.start ? 1'b1 : busy_in;
         done_ff <= cmd.start ? 1'b0 : done_in;
      end
   end

endmodule

// File: hdl/smlse_back.sv
// ----------------------------------------------------------------------------
// smlse_back
// Back end: loads the set, then runs exp, log and weight through the ALU.
// ----------------------------------------------------------------------------
module smlse_back #(
   parameter int MAX_HEIGHTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [30:0]            csr_wr_data,
   input  smlse_pkg::fq_type      fq,
   output logic                   pop,
   output smlse_pkg::alu_cmd_type alu_cmd,
   input  smlse_pkg::alu_rsp_type alu_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smlse_pkg::rsp_type     rsp_data
);
   import smlse_pkg::*;

   localparam int IDX_W = (MAX_HEIGHTS > 1) ? $clog2(MAX_HEIGHTS) : 1;

   typedef enum logic [22:0] {
      ST_LOAD    = 23'h000001,
      ST_WAIT    = 23'h000002,
      ST_X_GO    = 23'h000004,
      ST_X_DONE  = 23'h000008,
      ST_T_MUL   = 23'h000010,
      ST_T_DIV   = 23'h000020,
      ST_T_ACC   = 23'h000040,
      ST_V_CHK   = 23'h000080,
      ST_V_DONE  = 23'h000100,
      ST_STORE_E = 23'h000200,
      ST_L_Q     = 23'h000400,
      ST_L_NORM  = 23'h000800,
      ST_SHIFT   = 23'h001000,
      ST_Z_DONE  = 23'h002000,
      ST_Z2_DONE = 23'h004000,
      ST_P_DIV   = 23'h008000,
      ST_P_ACC   = 23'h010000,
      ST_P_MUL   = 23'h020000,
      ST_FIN_M   = 23'h040000,
      ST_SOFT    = 23'h080000,
      ST_W_GO    = 23'h100000,
      ST_W_DONE  = 23'h200000,
      ST_EMIT    = 23'h400000
   } state_type;

   logic signed [31:0] height_store [MAX_HEIGHTS];
   logic [16:0]        exp_store    [MAX_HEIGHTS];

   state_type          st_ff, st_in, ret_ff, ret_in;
   logic [30:0]        smooth_ff;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [31:0] min_ff, min_in;
   logic [20:0]        sum_ff, sum_in;
   logic               drop_ff, drop_in;
   logic [4:0]         idx_ff, idx_in;
   logic [3:0]         n_ff, n_in;
   logic [31:0]        r_ff, r_in;
   logic [32:0]        t_ff, t_in;
   logic signed [34:0] tacc_ff, tacc_in;
   logic [3:0]         ti_ff, ti_in;
   logic [32:0]        v_ff, v_in;
   logic [32:0]        q_ff, q_in;
   logic [39:0]        klog_ff, klog_in;
   logic [31:0]        z2_ff, z2_in;
   logic [31:0]        p_ff, p_in;
   logic [2:0]         j_ff, j_in;
   logic [34:0]        lacc_ff, lacc_in;
   logic signed [31:0] soft_ff, soft_in;
   logic [16:0]        w_ff, w_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic signed [31:0] h_rd_ff;
   logic [16:0]        e_rd_ff;

   logic [30:0]        s_eff;
   logic               store_h;
   logic               store_e;
   logic [16:0]        e_val;
   logic signed [32:0] u_diff;
   logic signed [34:0] tacc_nx;
   logic [64:0]        v_round;
   logic [35:0]        twice;
   logic [39:0]        m_val;
   logic [64:0]        d_round;
   logic signed [40:0] tot;
   logic               last_idx;

   assign s_eff     = (smooth_ff == 31'd0) ? 31'd1 : smooth_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign last_idx  = (idx_ff == cnt_ff - 5'd1);

   always_comb begin
      st_in        = st_ff;
      ret_in       = ret_ff;
      cnt_in       = cnt_ff;
      min_in       = min_ff;
      sum_in       = sum_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      tacc_in      = tacc_ff;
      ti_in        = ti_ff;
      v_in         = v_ff;
      q_in         = q_ff;
      klog_in      = klog_ff;
      z2_in        = z2_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      lacc_in      = lacc_ff;
      soft_in      = soft_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      store_h      = 1'b0;
      store_e      = 1'b0;
      alu_cmd      = '0;
      e_val        = v_ff[32:16] + {16'd0, v_ff[15]};
      u_diff       = {h_rd_ff[31], h_rd_ff} - {min_ff[31], min_ff};
      tacc_nx      = ti_ff[0] ? (tacc_ff - $signed({2'b00, alu_rsp.lo[32:0]}))
                              : (tacc_ff + $signed({2'b00, alu_rsp.lo[32:0]}));
      v_round      = {1'b0, alu_rsp.lo} + 65'h0_8000_0000;
      twice        = {lacc_ff, 1'b0};
      m_val        = (klog_ff <= {4'd0, twice}) ? 40'd0 : (klog_ff - {4'd0, twice});
      d_round      = {1'b0, alu_rsp.lo} + 65'h0_0080_0000;
      tot          = {{9{min_ff[31]}}, min_ff} + $signed({1'b0, d_round[63:24]});

      case (st_ff)
         ST_LOAD: begin
            pop = fq.valid;
            if (fq.valid) begin
               if (cnt_ff < 5'(MAX_HEIGHTS)) begin
                  store_h = 1'b1;
                  cnt_in  = cnt_ff + 5'd1;
                  if (fq.item.height < min_ff) begin
                     min_in = fq.item.height;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (fq.item.set_end) begin
                  sum_in = 21'd0;
                  idx_in = 5'd0;
                  st_in  = ST_X_GO;
               end
            end
         end
         ST_WAIT: begin
            if (alu_rsp.done) begin
               st_in = ret_ff;
            end
         end
         ST_X_GO: begin
            alu_cmd.start  = 1'b1;
            alu_cmd.is_div = 1'b1;
            alu_cmd.a      = {15'd0, u_diff, 16'd0};
            alu_cmd.b      = {33'd0, s_eff};
            ret_in         = ST_X_DONE;
            st_in          = ST_WAIT;
         end
         ST_X_DONE: begin
            if (alu_rsp.lo >= EXP_CUTOFF) begin
               v_in  = 33'd0;
               st_in = ST_STORE_E;
            end else begin
               n_in    = alu_rsp.lo[19:16];
               r_in    = {alu_rsp.lo[15:0], 16'd0};
               t_in    = Q32_ONE[32:0];
               tacc_in = $signed({2'b00, Q32_ONE[32:0]});
               ti_in   = 4'd1;
               st_in   = ST_T_MUL;
            end
         end
         ST_T_MUL: begin
            alu_cmd.start = 1'b1;
            alu_cmd.a     = {31'd0, t_ff};
            alu_cmd.b     = {32'd0, r_ff};
            ret_in        = ST_T_DIV;
            st_in         = ST_WAIT;
         end
         ST_T_DIV: begin
            alu_cmd.start  = 1'b1;
            alu_cmd.is_div = 1'b1;
            alu_cmd.a      = {32'd0, alu_rsp.lo[63:32]};
            alu_cmd.b      = {60'd0, ti_ff};
            ret_in         = ST_T_ACC;
            st_in          = ST_WAIT;
         end
         ST_T_ACC: begin
            t_in    = alu_rsp.lo[32:0];
            tacc_in = tacc_nx;
            if (ti_ff == TAYLOR_LAST) begin
               v_in  = tacc_nx[34] ? 33'd0 : tacc_nx[32:0];
               st_in = ST_V_CHK;
            end else begin
               ti_in = ti_ff + 4'd1;
               st_in = ST_T_MUL;
            end
         end
         ST_V_CHK: begin
            if (n_ff == 4'd0) begin
               st_in = ST_STORE_E;
            end else begin
               alu_cmd.start = 1'b1;
               alu_cmd.a     = {31'd0, v_ff};
               alu_cmd.b     = EXP_NEG_ONE;
               ret_in        = ST_V_DONE;
               st_in         = ST_WAIT;
            end
         end
         ST_V_DONE: begin
            v_in  = v_round[64:32];
            n_in  = n_ff - 4'd1;
            st_in = ST_V_CHK;
         end
         ST_STORE_E: begin
            store_e = 1'b1;
            sum_in  = sum_ff + {4'd0, e_val};
            if (last_idx) begin
               st_in = ST_L_Q;
            end else begin
               idx_in = idx_ff + 5'd1;
               st_in  = ST_X_GO;
            end
         end
         ST_L_Q: begin
            alu_cmd.start  = 1'b1;
            alu_cmd.is_div = 1'b1;
            alu_cmd.a      = {27'd0, sum_ff, 16'd0};
            alu_cmd.b      = {59'd0, cnt_ff};
            ret_in         = ST_L_NORM;
            st_in          = ST_WAIT;
         end
         ST_L_NORM: begin
            q_in    = alu_rsp.lo[32:0];
            klog_in = 40'd0;
            lacc_in = 35'd0;
            st_in   = (alu_rsp.lo == 64'd0) ? ST_FIN_M : ST_SHIFT;
         end
         ST_SHIFT: begin
            if (!q_ff[32]) begin
               // normalize q into [1, 2) one bit a cycle
               q_in    = {q_ff[31:0], 1'b0};
               klog_in = klog_ff + LN_TWO;
            end else begin
               alu_cmd.start  = 1'b1;
               alu_cmd.is_div = 1'b1;
               alu_cmd.a      = {q_ff[31:0], 32'd0};
               alu_cmd.b      = {31'd0, q_ff} + Q32_ONE;
               ret_in         = ST_Z_DONE;
               st_in          = ST_WAIT;
            end
         end
         ST_Z_DONE: begin
            p_in          = alu_rsp.lo[31:0];
            alu_cmd.start = 1'b1;
            alu_cmd.a     = {32'd0, alu_rsp.lo[31:0]};
            alu_cmd.b     = {32'd0, alu_rsp.lo[31:0]};
            ret_in        = ST_Z2_DONE;
            st_in         = ST_WAIT;
         end
         ST_Z2_DONE: begin
            z2_in   = alu_rsp.lo[63:32];
            lacc_in = 35'd0;
            j_in    = 3'd0;
            st_in   = ST_P_DIV;
         end
         ST_P_DIV: begin
            alu_cmd.start  = 1'b1;
            alu_cmd.is_div = 1'b1;
            alu_cmd.a      = {32'd0, p_ff};
            alu_cmd.b      = {60'd0, j_ff, 1'b1};
            ret_in         = ST_P_ACC;
            st_in          = ST_WAIT;
         end
         ST_P_ACC: begin
            lacc_in = lacc_ff + {3'd0, alu_rsp.lo[31:0]};
            if (j_ff == LOG_LAST) begin
               st_in = ST_FIN_M;
            end else begin
               alu_cmd.start = 1'b1;
               alu_cmd.a     = {32'd0, p_ff};
               alu_cmd.b     = {32'd0, z2_ff};
               ret_in        = ST_P_MUL;
               st_in         = ST_WAIT;
            end
         end
         ST_P_MUL: begin
            p_in  = alu_rsp.lo[63:32];
            j_in  = j_ff + 3'd1;
            st_in = ST_P_DIV;
         end
         ST_FIN_M: begin
            alu_cmd.start = 1'b1;
            alu_cmd.a     = {32'd0, m_val[39:8]};
            alu_cmd.b     = {33'd0, s_eff};
            ret_in        = ST_SOFT;
            st_in         = ST_WAIT;
         end
         ST_SOFT: begin
            soft_in = (tot > 41'sd2147483647) ? MIN_RESET : tot[31:0];
            idx_in  = 5'd0;
            st_in   = ST_W_GO;
         end
         ST_W_GO: begin
            if (sum_ff == 21'd0) begin
               w_in  = 17'd0;
               st_in = ST_EMIT;
            end else begin
               alu_cmd.start  = 1'b1;
               alu_cmd.is_div = 1'b1;
               alu_cmd.a      = {31'd0, e_rd_ff, 16'd0} + {44'd0, sum_ff[20:1]};
               alu_cmd.b      = {43'd0, sum_ff};
               ret_in         = ST_W_DONE;
               st_in          = ST_WAIT;
            end
         end
         ST_W_DONE: begin
            w_in  = alu_rsp.lo[16:0];
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.soft_min      = soft_ff;
               rsp_data_in.weight        = w_ff;
               rsp_data_in.height_index  = idx_ff[3:0];
               rsp_data_in.run_end       = last_idx;
               rsp_data_in.overflow      = drop_ff;
               if (last_idx) begin
                  cnt_in  = 5'd0;
                  min_in  = MIN_RESET;
                  sum_in  = 21'd0;
                  drop_in = 1'b0;
                  st_in   = ST_LOAD;
               end else begin
                  idx_in = idx_ff + 5'd1;
                  st_in  = ST_W_GO;
               end
            end
         end
         default: begin
            st_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_h) begin
         height_store[cnt_ff[IDX_W-1:0]] <= fq.item.height;
      end
      if (store_e) begin
         exp_store[idx_ff[IDX_W-1:0]] <= e_val;
      end
      // read ahead at the next index; forward a height written this cycle
      if (store_h && (cnt_ff[IDX_W-1:0] == idx_in[IDX_W-1:0])) begin
         h_rd_ff <= fq.item.height;
      end else begin
         h_rd_ff <= height_store[idx_in[IDX_W-1:0]];
      end
      e_rd_ff <= exp_store[idx_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      r_ff        <= r_in;
      t_ff        <= t_in;
      tacc_ff     <= tacc_in;
      ti_ff       <= ti_in;
      v_ff        <= v_in;
      q_ff        <= q_in;
      klog_ff     <= klog_in;
      z2_ff       <= z2_in;
      p_ff        <= p_in;
      j_ff        <= j_in;
      lacc_ff     <= lacc_in;
      soft_ff     <= soft_in;
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
      ret_ff      <= ret_in;
      idx_ff      <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_LOAD;
         smooth_ff    <= SMOOTH_RESET;
         cnt_ff       <= 5'd0;
         min_ff       <= MIN_RESET;
         sum_ff       <= 21'd0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         smooth_ff    <= csr_wr_en ? csr_wr_data : smooth_ff;
         cnt_ff       <= cnt_in;
         min_ff       <= min_in;
         sum_ff       <= sum_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/soft_minimum_log_sum_exp_top.sv
// ----------------------------------------------------------------------------
// soft_minimum_log_sum_exp_top
// Soft minimum of a set of heights by log-sum-exp, with per-height weights.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed Q16.16 height per word; set_end closes the set.
//   A two-word queue takes heights while the back end is busy; req_stall
//   rises only when that queue is full.
//   A closed set produces one rsp_* word per stored height, in load order,
//   with soft_min, weight, index, run_end on the last one and overflow if
//   heights beyond MAX_HEIGHTS were dropped.
//   csr_wr_en/csr_wr_data write the smoothing scale (0 acts as 1); write it
//   only while the block is idle.
// Operation:
//   Loading takes one height per cycle while the queue holds one. All
//   arithmetic runs on one shared bit-serial multiply/divide unit: 1 to 38
//   operations per height for exp, up to 19 for the log and final scaling,
//   and one divide per result for its weight. The next set loads after the
//   last word of a set.
// Reset clears the set, the queue and the output register and loads the
// smoothing scale with 655. A stalled result holds in the output register
// and the back end waits before loading the next one.
// ----------------------------------------------------------------------------
module soft_minimum_log_sum_exp_top #(
   parameter int MAX_HEIGHTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  smlse_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output smlse_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data
);
   import smlse_pkg::*;

   fq_type      fq;
   logic        pop;
   alu_cmd_type alu_cmd;
   alu_rsp_type alu_rsp;

   smlse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fq        (fq),
      .pop       (pop)
   );

   smlse_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

   smlse_back #(
      .MAX_HEIGHTS (MAX_HEIGHTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fq          (fq),
      .pop         (pop),
      .alu_cmd     (alu_cmd),
      .alu_rsp     (alu_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: hdl/smlse_checker.sv
// ----------------------------------------------------------------------------
// smlse_checker
// Port-level checks of the soft-minimum block, bound to the top level.
// ----------------------------------------------------------------------------
module smlse_checker #(
   parameter int MAX_HEIGHTS = 8
) (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input smlse_pkg::rsp_type rsp_data
);
   import smlse_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.weight <= 17'd65536)
      else $error("weight above one");

   a_index_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.height_index <= 4'(MAX_HEIGHTS - 1))
      else $error("index beyond capacity");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind soft_minimum_log_sum_exp_top smlse_checker #(
   .MAX_HEIGHTS (MAX_HEIGHTS)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/soft_minimum_log_sum_exp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_minimum_log_sum_exp_checker
// Watches the height and result channels of the soft-minimum block, predicts
// every result word from the accepted heights and the smoothing register, and
// compares each accepted result word field by field in order.
// ----------------------------------------------------------------------------
module soft_minimum_log_sum_exp_checker #(
   parameter int MAX_HEIGHTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  smlse_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  smlse_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   output int                 fail_count,
   output int                 pending
);
   import smlse_pkg::*;

   localparam logic [63:0] E_NEG1 = 64'd1580030169;
   localparam logic [63:0] LN2    = 64'd2977044472;
   localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

   longint      set_heights[MAX_HEIGHTS];
   logic [16:0] set_exps[MAX_HEIGHTS];
   int          set_count;
   longint      set_min;
   logic        set_dropped;
   logic [30:0] smooth_scale;
   rsp_type     expected_words[$];

   assign pending = expected_words.size();

   function automatic logic [16:0] exp_of_neg(logic [63:0] x);
      logic [63:0] n, r, t, v;
      longint      acc;
      if (x >= 64'd786432)
         return 17'd0;
      n   = x >> 16;
      r   = (x & 64'hFFFF) << 16;
      t   = ONE_Q32;
      acc = longint'(ONE_Q32);
      for (int i = 1; i <= 13; i++) begin
         t = (t * r) >> 32;
         t = t / 64'(i);
         if (i % 2 == 1)
            acc -= longint'(t);
         else
            acc += longint'(t);
      end
      if (acc < 0)
         acc = 0;
      v = 64'(acc);
      for (logic [63:0] i = 0; i < n; i++)
         v = (v * E_NEG1 + 64'h8000_0000) >> 32;
      return 17'((v + 64'd32768) >> 16);
   endfunction

   // magnitude of ln(sum/count) in Q32
   function automatic logic [63:0] log_ratio_mag(logic [63:0] sum, logic [63:0] count);
      logic [63:0] q, z, z2, p, acc, k, twice;
      if (count == 0)
         count = 1;
      q = (sum << 16) / count;
      if (q == 0)
         return 0;
      k = 0;
      while (q < ONE_Q32) begin
         q = q << 1;
         k++;
      end
      z   = ((q - ONE_Q32) << 32) / (q + ONE_Q32);
      z2  = (z * z) >> 32;
      p   = z;
      acc = 0;
      for (int j = 0; j < 8; j++) begin
         acc += p / 64'(2 * j + 1);
         p = (p * z2) >> 32;
      end
      twice = 2 * acc;
      if (k * LN2 <= twice)
         return 0;
      return k * LN2 - twice;
   endfunction

   task automatic clear_set();
      set_count   = 0;
      set_min     = 64'sd2147483647;
      set_dropped = 1'b0;
   endtask

   task automatic take_height(req_type w);
      longint      h;
      logic [63:0] s, m, delta, sum, u, wgt;
      longint      soft_val;
      rsp_type     r;
      h = w.height;
      if (set_count < MAX_HEIGHTS) begin
         set_heights[set_count] = h;
         set_count++;
         if (h < set_min)
            set_min = h;
      end else begin
         set_dropped = 1'b1;
      end
      if (!w.set_end)
         return;
      s   = (smooth_scale == 0) ? 64'd1 : 64'(smooth_scale);
      sum = 0;
      for (int i = 0; i < set_count; i++) begin
         u           = 64'(set_heights[i] - set_min);
         set_exps[i] = exp_of_neg((u << 16) / s);
         sum         = (sum + 64'(set_exps[i])) & 64'h1F_FFFF;
      end
      m     = log_ratio_mag(sum, 64'(set_count));
      delta = (s * (m >> 8) + 64'h80_0000) >> 24;
      if (delta > 64'(64'sd2147483647 - set_min))
         soft_val = 64'sd2147483647;
      else
         soft_val = set_min + longint'(delta);
      for (int i = 0; i < set_count; i++) begin
         wgt = 0;
         if (sum != 0)
            wgt = ((64'(set_exps[i]) << 16) + (sum >> 1)) / sum;
         r.soft_min     = soft_val[31:0];
         r.weight       = wgt[16:0];
         r.height_index = 4'(i);
         r.run_end      = (i + 1 == set_count);
         r.overflow     = set_dropped;
         expected_words = {expected_words, r};
      end
      clear_set();
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_set();
         smooth_scale = SMOOTH_RESET;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en)
            smooth_scale = csr_wr_data;
         if (req_valid && !req_stall)
            take_height(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with none expected: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.soft_min !== want.soft_min) begin
                  $error("soft_min: expected %0d, got %0d", want.soft_min, rsp_data.soft_min);
                  fail_count++;
               end
               if (rsp_data.weight !== want.weight) begin
                  $error("weight: expected %0d, got %0d", want.weight, rsp_data.weight);
                  fail_count++;
               end
               if (rsp_data.height_index !== want.height_index) begin
                  $error("height_index: expected %0d, got %0d", want.height_index,
                         rsp_data.height_index);
                  fail_count++;
               end
               if (rsp_data.run_end !== want.run_end) begin
                  $error("run_end: expected %0d, got %0d", want.run_end, rsp_data.run_end);
                  fail_count++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_data.overflow);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// File: bench/soft_minimum_log_sum_exp_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_minimum_log_sum_exp_top_tb
// Drives directed and random sets of heights into the soft-minimum block
// under several smoothing scales and idle patterns; the checker predicts and
// compares every result word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module soft_minimum_log_sum_exp_top_tb;
   import smlse_pkg::*;

   localparam int MAX_HEIGHTS = 8;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int SETTLE      = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          send_idle_pct;
   int          recv_idle_pct;

   soft_minimum_log_sum_exp_top #(.MAX_HEIGHTS(MAX_HEIGHTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   soft_minimum_log_sum_exp_checker #(.MAX_HEIGHTS(MAX_HEIGHTS)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   task automatic send_word(logic signed [31:0] h, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data.height   <= h;
      req_data.set_end  <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // mostly heights near a common base so that weights spread out
   task automatic send_set(int n, ref int sent);
      logic signed [31:0] base, h;
      base = $urandom;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0:       h = $urandom;
            1:       h = base + $signed(32'($urandom_range(65535)) - 32'sd32768);
            default: h = base + 32'($urandom_range(4 * 65536));
         endcase
         send_word(h, i == n - 1);
      end
      sent += n;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_smoothing(logic [30:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int          sent;
      int          n;
      logic [30:0] scales[5];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      send_idle_pct = 27;
      recv_idle_pct = 77;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed sets under the reset scale
      send_word(32'sh7FFF_FFFF, 1'b1);
      send_word(32'sh8000_0000, 1'b1);
      send_word(32'sh8000_0000, 1'b0);
      send_word(32'sh7FFF_FFFF, 1'b1);
      for (int i = 0; i < 4; i++)
         send_word(32'sd0, i == 3);
      for (int i = 0; i < MAX_HEIGHTS; i++)
         send_word(32'sd300 * i, i == MAX_HEIGHTS - 1);
      // overflow, closed by a dropped height
      for (int i = 0; i < MAX_HEIGHTS + 2; i++)
         send_word(-32'sd500 * i, i == MAX_HEIGHTS + 1);

      scales[0] = 31'd0;
      scales[1] = 31'd1;
      scales[2] = 31'd65536;
      scales[3] = 31'h7FFF_FFFF;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 77 : 0;
         recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 27 : 0;
         for (int c = 0; c < 5; c++) begin
            drain();
            scales[4] = 31'($urandom_range(200000, 1));
            write_smoothing(scales[c]);
            sent = 0;
            while (sent < 13) begin
               case ($urandom_range(19))
                  0:       n = $urandom_range(MAX_HEIGHTS + 3, MAX_HEIGHTS + 1);
                  1, 2:    n = $urandom_range(MAX_HEIGHTS, 4);
                  default: n = $urandom_range(3, 1);
               endcase
               send_set(n, sent);
            end
         end
      end
      drain();

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
